// File: design/ccds_pkg.sv
// shared types and constants for the complex central difference stencil
package ccds_pkg;

    localparam int MAX_RADIUS  = 6;
    localparam int SAMPLE_W    = 32;
    localparam int GAIN_W      = 32;
    localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 1;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int NUM_TAPS    = MAX_RADIUS + 1;
    localparam int GAIN_IDX_W  = $clog2(NUM_TAPS);
    localparam int SPLIT_TAPS  = (NUM_TAPS + 1) / 2;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = DIFF_W + GAIN_W;
    localparam int SUM_W       = PROD_W + $clog2(NUM_TAPS + 1);
    localparam int FRAC_SHIFT  = 24;
    localparam int SHIFT_W     = SUM_W - FRAC_SHIFT;
    localparam int RADIUS_W    = 3;
    localparam int FILL_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_MAX   = RADIUS_W'(MAX_RADIUS);
    localparam logic [FILL_W-1:0]   FILL_MAX     = '1;
    localparam logic [FILL_W-1:0]   FILL_FIRST   = FILL_W'(1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [GAIN_W-1:0]   t_gain;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SUM_W-1:0]    t_sum;

    localparam t_sum    ROUND_HALF = t_sum'(1) <<< (FRAC_SHIFT - 1);
    localparam t_sample SAT_MAX    = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAT_MIN    = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS,
        CFG_CENTER_GAIN,
        CFG_COEF_ONE,
        CFG_COEF_TWO,
        CFG_COEF_THREE,
        CFG_COEF_FOUR,
        CFG_COEF_FIVE,
        CFG_COEF_SIX
    } t_cfg_idx;

    // load enables of the back end pipeline stages
    typedef struct packed {
        logic en_prod;
        logic en_sum;
        logic en_out;
    } t_stage_en;

endpackage

// File: design/ccds_lane.sv
// multiply, sum, round and saturate pipeline for one complex component
module ccds_lane (
    input  logic                i_clk,
    input  ccds_pkg::t_stage_en i_en,
    input  ccds_pkg::t_diff     i_tap  [ccds_pkg::NUM_TAPS],
    input  ccds_pkg::t_gain     i_gain [ccds_pkg::NUM_TAPS],
    output ccds_pkg::t_sample   o_result
);
    import ccds_pkg::*;

    t_prod   r_prod [NUM_TAPS];
    t_sum    r_sum_a;
    t_sum    r_sum_b;
    t_sum    n_sum_a;
    t_sum    n_sum_b;
    t_sum    n_total;
    logic [SHIFT_W-1:0] n_shifted;
    t_sample n_result;
    t_sample r_result;

    // one product per tap, center tap at index zero
    always_ff @(posedge i_clk) begin
        if (i_en.en_prod) begin
            for (int i = 0; i < NUM_TAPS; i++) begin
                r_prod[i] <= i_tap[i] * i_gain[i];
            end
        end
    end

    // two partial sums, rounding half folded into the first
    always_comb begin
        n_sum_a = ROUND_HALF;
        n_sum_b = '0;
        for (int i = 0; i < NUM_TAPS; i++) begin
            if (i < SPLIT_TAPS) begin
                n_sum_a = n_sum_a + t_sum'(r_prod[i]);
            end else begin
                n_sum_b = n_sum_b + t_sum'(r_prod[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_sum) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    // final add, drop fraction bits, saturate
    always_comb begin
        n_total   = r_sum_a + r_sum_b;
        n_shifted = n_total[SUM_W-1:FRAC_SHIFT];
        if ((&n_shifted[SHIFT_W-1:SAMPLE_W-1]) || !(|n_shifted[SHIFT_W-1:SAMPLE_W-1])) begin
            n_result = n_shifted[SAMPLE_W-1:0];
        end else if (n_shifted[SHIFT_W-1]) begin
            n_result = SAT_MIN;
        end else begin
            n_result = SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_out) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// File: design/complex_central_difference_stencil.sv
// top level of the complex central difference first derivative stencil
//
// Samples of one extended grid line (halo included) enter on the s_axis
// channel, one beat per sample; tuser marks the first sample of a line and
// restarts the fill count. From the beat that brings 2*radius+1 samples of
// the line on, each beat yields one complex result on m_axis: the
// derivative at the window center, center_gain*x + sum coef_k*(x[+k]-x[-k]),
// rounded to Q16.16 and saturated. Beats before that yield nothing.
// Registers are written on the cfg channel, which is always ready; write
// them only while no result is outstanding.
// Throughput is one sample per clock while s_axis_tready is high. A result
// passes these stages on its way to the output register: stage one selects
// taps and forms the differences, stage two multiplies, stage three forms
// partial sums, stage four adds, rounds and saturates.
// When the receiver stalls, the result holds and the pipeline keeps filling
// its empty stages; s_axis_tready drops only when every stage holds a result.
// Reset clears the fill count, the stage valid bits and the registers
// (radius six, all gains zero).
module complex_central_difference_stencil (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [2*ccds_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // sample_re, sample_im
    input  logic                               s_axis_tuser,  // line_start
    // result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [2*ccds_pkg::SAMPLE_W-1:0]    m_axis_tdata,  // result_re, result_im
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ccds_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ccds_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ccds_pkg::*;

    // configuration registers
    logic [RADIUS_W-1:0] r_radius;
    t_gain               r_gain [NUM_TAPS];

    // line window and fill count
    t_sample             r_win_re [WIN_DEPTH-1];
    t_sample             r_win_im [WIN_DEPTH-1];
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;

    // stage valid bits
    logic                r_v_tap;
    logic                r_v_prod;
    logic                r_v_sum;
    logic                r_v_out;
    logic                en_tap;
    logic                en_prod;
    logic                en_sum;
    logic                en_out;
    t_stage_en           stage_en;

    // tap stage
    t_sample             w_re [WIN_DEPTH];
    t_sample             w_im [WIN_DEPTH];
    logic [RADIUS_W-1:0] r_eff;
    logic                accept;
    logic                emit;
    t_diff               n_tap_re [NUM_TAPS];
    t_diff               n_tap_im [NUM_TAPS];
    t_diff               r_tap_re [NUM_TAPS];
    t_diff               r_tap_im [NUM_TAPS];
    t_sample             res_re;
    t_sample             res_im;

    // register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_MAX;
            for (int i = 0; i < NUM_TAPS; i++) begin
                r_gain[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RADIUS: begin
                    r_radius <= i_cfg_data[RADIUS_W-1:0];
                end
                default: begin
                    r_gain[GAIN_IDX_W'(i_cfg_index - CFG_CENTER_GAIN)] <= i_cfg_data;
                end
            endcase
        end
    end

    // ready chain, a stage loads when empty or when the next one loads
    assign en_out  = !r_v_out  || m_axis_tready;
    assign en_sum  = !r_v_sum  || en_out;
    assign en_prod = !r_v_prod || en_sum;
    assign en_tap  = !r_v_tap  || en_prod;

    assign stage_en = '{en_prod: en_prod, en_sum: en_sum, en_out: en_out};

    assign s_axis_tready = en_tap;
    assign accept        = s_axis_tvalid && en_tap;

    // window as seen after the incoming beat is shifted in
    always_comb begin
        w_re[0] = s_axis_tdata[SAMPLE_W-1:0];
        w_im[0] = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        for (int j = 1; j < WIN_DEPTH; j++) begin
            w_re[j] = r_win_re[j-1];
            w_im[j] = r_win_im[j-1];
        end
    end

    // fill count and result decision
    always_comb begin
        r_eff = (r_radius > RADIUS_MAX) ? RADIUS_MAX : r_radius;
        if (s_axis_tuser) begin
            n_fill = FILL_FIRST;
        end else if (r_fill == FILL_MAX) begin
            n_fill = FILL_MAX;
        end else begin
            n_fill = r_fill + FILL_FIRST;
        end
        emit = (n_fill >= {r_eff, 1'b1});
    end

    // center sample and the symmetric differences
    always_comb begin
        n_tap_re[0] = t_diff'(w_re[WIN_IDX_W'(r_eff)]);
        n_tap_im[0] = t_diff'(w_im[WIN_IDX_W'(r_eff)]);
        for (int k = 1; k < NUM_TAPS; k++) begin
            if (RADIUS_W'(k) <= r_eff) begin
                n_tap_re[k] = t_diff'(w_re[WIN_IDX_W'(r_eff) - WIN_IDX_W'(k)])
                            - t_diff'(w_re[WIN_IDX_W'(r_eff) + WIN_IDX_W'(k)]);
                n_tap_im[k] = t_diff'(w_im[WIN_IDX_W'(r_eff) - WIN_IDX_W'(k)])
                            - t_diff'(w_im[WIN_IDX_W'(r_eff) + WIN_IDX_W'(k)]);
            end else begin
                n_tap_re[k] = '0;
                n_tap_im[k] = '0;
            end
        end
    end

    // window shift on every accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int j = 0; j < WIN_DEPTH - 1; j++) begin
                r_win_re[j] <= w_re[j];
                r_win_im[j] <= w_im[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    // tap stage register
    always_ff @(posedge i_clk) begin
        if (en_tap) begin
            r_tap_re <= n_tap_re;
            r_tap_im <= n_tap_im;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_tap  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (en_tap) begin
                r_v_tap <= accept && emit;
            end
            if (en_prod) begin
                r_v_prod <= r_v_tap;
            end
            if (en_sum) begin
                r_v_sum <= r_v_prod;
            end
            if (en_out) begin
                r_v_out <= r_v_sum;
            end
        end
    end

    // one back end per component, same gains
    ccds_lane u_lane_re (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_tap    (r_tap_re),
        .i_gain   (r_gain),
        .o_result (res_re)
    );

    ccds_lane u_lane_im (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_tap    (r_tap_im),
        .i_gain   (r_gain),
        .o_result (res_im)
    );

    assign m_axis_tvalid = r_v_out;
    assign m_axis_tdata  = {res_im, res_re};

endmodule

// File: design/ccds_checker.sv
// port level checks for the stencil, bound to the top level
module ccds_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [2*ccds_pkg::SAMPLE_W-1:0]    m_axis_tdata,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready
);

    // no result survives a reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // register writes never wait
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("register write not taken");

    // input only backs up when the output is full and stalled
    a_input_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output can drain");

    // stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind complex_central_difference_stencil ccds_checker u_ccds_checker (.*);
